// ===== rtl/text_line_index_and_lookup_assert.svh =====
// Assertion macros used by the checker file of the text line index block.
`ifndef TEXT_LINE_INDEX_AND_LOOKUP_ASSERT_SVH
`define TEXT_LINE_INDEX_AND_LOOKUP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TLIL_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TLIL_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tlil_pkg.sv =====
// Package with the types, codes and constants of the text line index block.
package tlil_pkg;

    localparam int REQ_W    = 2;
    localparam int BYTE_W   = 8;
    localparam int QUERY_W  = 17;
    localparam int LINE_W   = 13;
    localparam int COL_W    = 17;
    localparam int STATUS_W = 2;

    localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_UNUSED   = 2'd3;

    localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef enum logic [2:0] {
        OP_APPEND_LF,
        OP_APPEND_CR,
        OP_APPEND_OTHER,
        OP_QUERY,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [QUERY_W-1:0] offset;
    } cmd_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_CMP,
        B_DONE
    } back_state_t;

endpackage

// ===== rtl/tlil_in_if.sv =====
// Request channel interface of the text line index block.
interface tlil_in_if;
    logic                          valid;
    logic                          ready;
    logic [tlil_pkg::REQ_W-1:0]    req_type;
    logic [tlil_pkg::BYTE_W-1:0]   text_byte;
    logic [tlil_pkg::QUERY_W-1:0]  query_offset;

    modport source (output valid, req_type, text_byte, query_offset, input ready);
    modport sink (input valid, req_type, text_byte, query_offset, output ready);
endinterface

// ===== rtl/tlil_out_if.sv =====
// Result channel interface of the text line index block.
interface tlil_out_if;
    logic                           valid;
    logic                           ready;
    logic [tlil_pkg::LINE_W-1:0]    line_number;
    logic [tlil_pkg::COL_W-1:0]     column_number;
    logic [tlil_pkg::STATUS_W-1:0]  status;

    modport source (output valid, line_number, column_number, status, input ready);
    modport sink (input valid, line_number, column_number, status, output ready);
endinterface

// ===== rtl/text_line_index_and_lookup.sv =====
// Top level of the text line index and offset lookup block.
// The request channel carries one transaction per text byte, query or clear.
// Appended bytes build a table of line start offsets; LF, a lone CR and a
// CR LF pair each count as one line break. A query returns one transaction on
// the result channel with a one-based line and column, or a range error status.
// Appends and clears return nothing. Requests pass through a four-entry command
// queue, so the request channel keeps taking transactions while a search runs.
// An append or clear is handled in the idle state without leaving it. A query
// runs a binary search over the recorded line starts, one table memory read
// and one compare per step, held in the states B_READ and B_CMP, and ends in
// B_DONE; an offset beyond the text goes straight to B_DONE.
// A finished result waits in an output register while the receiver stalls;
// the engine then holds, and the queue fills before the request channel stalls.
// Reset empties the text buffer and the queue; the start table is not cleared.
module text_line_index_and_lookup #(
    parameter int MAX_LINES = 4096,
    parameter int MAX_BYTES = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    tlil_in_if.sink     request,
    tlil_out_if.source  result
);
    import tlil_pkg::*;

    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_cmd;

    tlil_front u_front (
        .request    (request),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    tlil_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    tlil_back #(
        .MAX_LINES (MAX_LINES),
        .MAX_BYTES (MAX_BYTES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (pop_valid),
        .q_ready (pop_ready),
        .q_cmd   (pop_cmd),
        .result  (result)
    );

endmodule

// ===== rtl/tlil_front.sv =====
// Front end that accepts requests and classifies them into commands.
module tlil_front (
    tlil_in_if.sink         request,
    output logic            push_valid,
    input  logic            push_ready,
    output tlil_pkg::cmd_t  push_cmd
);
    import tlil_pkg::*;

    assign request.ready   = push_ready;
    assign push_valid      = request.valid && (request.req_type != REQ_UNUSED);

    always_comb
    begin
        push_cmd.offset = request.query_offset;
        unique case (request.req_type)
            REQ_APPEND:
            begin
                if (request.text_byte == CHAR_LF)
                begin
                    push_cmd.op = OP_APPEND_LF;
                end
                else if (request.text_byte == CHAR_CR)
                begin
                    push_cmd.op = OP_APPEND_CR;
                end
                else
                begin
                    push_cmd.op = OP_APPEND_OTHER;
                end
            end
            REQ_QUERY:  push_cmd.op = OP_QUERY;
            REQ_CLEAR:  push_cmd.op = OP_CLEAR;
            REQ_UNUSED: push_cmd.op = OP_CLEAR;
        endcase
    end

endmodule

// ===== rtl/tlil_queue.sv =====
// Short command queue between the front end and the back end.
module tlil_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  tlil_pkg::cmd_t  push_cmd,
    output logic            pop_valid,
    input  logic            pop_ready,
    output tlil_pkg::cmd_t  pop_cmd
);
    import tlil_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   fill_reg;
    logic [QPTR_W:0]   fill_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (fill_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/tlil_back.sv =====
// Back end that keeps the line start table and answers queries by binary search.
module tlil_back #(
    parameter int MAX_LINES = 4096,
    parameter int MAX_BYTES = 65536
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    output logic            q_ready,
    input  tlil_pkg::cmd_t  q_cmd,
    tlil_out_if.source      result
);
    import tlil_pkg::*;

    localparam int AW = $clog2(MAX_LINES);
    localparam int CW = $clog2(MAX_LINES + 1);
    localparam int BW = $clog2(MAX_BYTES + 1);

    logic [BW-1:0] mem [MAX_LINES];

    back_state_t        state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [BW-1:0]      bytes_reg, bytes_next;
    logic               pending_reg, pending_next;
    logic               ovf_reg, ovf_next;
    logic [CW-1:0]      lo_reg, lo_next;
    logic [CW-1:0]      hi_reg, hi_next;
    logic [BW-1:0]      start_reg, start_next;
    logic [QUERY_W-1:0] off_reg, off_next;
    logic               err_reg, err_next;
    logic [BW-1:0]      rdata_reg;
    logic               out_valid_reg, out_valid_next;
    logic [LINE_W-1:0]  out_line_reg, out_line_next;
    logic [COL_W-1:0]   out_col_reg, out_col_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [BW-1:0]      wr_data;
    logic [CW-1:0]      mid;
    logic               byte_full;
    logic               table_full;
    logic [BW-1:0]      bytes_inc;
    logic [31:0]        line_wide;
    logic [31:0]        col_wide;

    assign mid        = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign byte_full  = (bytes_reg == BW'(MAX_BYTES));
    assign table_full = (count_reg == CW'(MAX_LINES));
    assign bytes_inc  = bytes_reg + 1'b1;
    assign line_wide  = 32'(lo_reg) + 32'd1;
    assign col_wide   = 32'(off_reg) - 32'(start_reg) + 32'd1;

    assign result.valid         = out_valid_reg;
    assign result.line_number   = out_line_reg;
    assign result.column_number = out_col_reg;
    assign result.status        = out_status_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        bytes_next      = bytes_reg;
        pending_next    = pending_reg;
        ovf_next        = ovf_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        start_next      = start_reg;
        off_next        = off_reg;
        err_next        = err_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_line_next   = out_line_reg;
        out_col_next    = out_col_reg;
        out_status_next = out_status_reg;
        q_ready         = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = AW'(count_reg);
        wr_data         = bytes_inc;

        unique case (state_reg)
            B_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    unique case (q_cmd.op)
                        OP_APPEND_LF:
                        begin
                            if (!byte_full)
                            begin
                                bytes_next   = bytes_inc;
                                pending_next = 1'b0;
                                if (pending_reg && (count_reg != '0))
                                begin
                                    wr_en   = 1'b1;
                                    wr_addr = AW'(count_reg - 1'b1);
                                end
                                else if (!table_full)
                                begin
                                    wr_en      = 1'b1;
                                    count_next = count_reg + 1'b1;
                                end
                                else
                                begin
                                    ovf_next = 1'b1;
                                end
                            end
                        end
                        OP_APPEND_CR:
                        begin
                            if (!byte_full)
                            begin
                                bytes_next   = bytes_inc;
                                pending_next = !table_full;
                                if (!table_full)
                                begin
                                    wr_en      = 1'b1;
                                    count_next = count_reg + 1'b1;
                                end
                                else
                                begin
                                    ovf_next = 1'b1;
                                end
                            end
                        end
                        OP_APPEND_OTHER:
                        begin
                            if (!byte_full)
                            begin
                                bytes_next   = bytes_inc;
                                pending_next = 1'b0;
                            end
                        end
                        OP_QUERY:
                        begin
                            off_next   = q_cmd.offset;
                            err_next   = (32'(q_cmd.offset) > 32'(bytes_reg));
                            lo_next    = '0;
                            hi_next    = count_reg;
                            start_next = '0;
                            state_next = (32'(q_cmd.offset) > 32'(bytes_reg)) ? B_DONE
                                                                               : B_READ;
                        end
                        OP_CLEAR:
                        begin
                            count_next   = '0;
                            bytes_next   = '0;
                            pending_next = 1'b0;
                            ovf_next     = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            B_READ:
            begin
                state_next = (lo_reg >= hi_reg) ? B_DONE : B_CMP;
            end
            B_CMP:
            begin
                if (32'(rdata_reg) <= 32'(off_reg))
                begin
                    lo_next    = mid + 1'b1;
                    start_next = rdata_reg;
                end
                else
                begin
                    hi_next = mid;
                end
                state_next = B_READ;
            end
            B_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    if (err_reg)
                    begin
                        out_line_next   = '0;
                        out_col_next    = '0;
                        out_status_next = STATUS_RANGE;
                    end
                    else
                    begin
                        out_line_next   = line_wide[LINE_W-1:0];
                        out_col_next    = col_wide[COL_W-1:0];
                        out_status_next = ovf_reg ? STATUS_OVERFLOW : STATUS_OK;
                    end
                    state_next = B_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            count_reg     <= '0;
            bytes_reg     <= '0;
            pending_reg   <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            bytes_reg     <= bytes_next;
            pending_reg   <= pending_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        start_reg      <= start_next;
        off_reg        <= off_next;
        err_reg        <= err_next;
        out_line_reg   <= out_line_next;
        out_col_reg    <= out_col_next;
        out_status_reg <= out_status_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[mid[AW-1:0]];
    end

endmodule

// ===== rtl/tlil_checker.sv =====
// Port checker for the result channel of the text line index block.
`include "text_line_index_and_lookup_assert.svh"

module tlil_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          valid,
    input logic                          ready,
    input logic [tlil_pkg::LINE_W-1:0]   line_number,
    input logic [tlil_pkg::COL_W-1:0]    column_number,
    input logic [tlil_pkg::STATUS_W-1:0] status
);
    import tlil_pkg::*;

    `TLIL_ASSERT_NEXT(a_hold_valid, clk, rst_n, valid && !ready, valid, "result dropped while stalled")
    `TLIL_ASSERT_NEXT(a_hold_data, clk, rst_n, valid && !ready, $stable(line_number) && $stable(column_number) && $stable(status), "result changed while stalled")
    `TLIL_ASSERT_IMPL(a_err_zero, clk, rst_n, valid && (status == STATUS_RANGE), (line_number == '0) && (column_number == '0), "range error with nonzero position")
    `TLIL_ASSERT_IMPL(a_ok_pos, clk, rst_n, valid && (status != STATUS_RANGE), (line_number != '0) && (column_number != '0) && (status != STATUS_UNUSED), "bad position or status")

endmodule

bind text_line_index_and_lookup tlil_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .valid         (result.valid),
    .ready         (result.ready),
    .line_number   (result.line_number),
    .column_number (result.column_number),
    .status        (result.status)
);

// ===== sim/text_line_index_and_lookup_tb.sv =====
// Self-checking testbench for the text line index and offset lookup block.
`timescale 1ns / 100ps

module text_line_index_and_lookup_tb;
    import tlil_pkg::*;

    localparam int TABLE_DEPTH  = 4096;
    localparam int BUFFER_BYTES = 65536;
    localparam int CYCLE_LIMIT  = 1500000;
    localparam int SETTLE_CYCLES = 64;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic [LINE_W-1:0]   line;
        logic [COL_W-1:0]    column;
        logic [STATUS_W-1:0] status;
    } line_pos_t;

    logic clk;
    logic rst_n;

    tlil_in_if  request_ch ();
    tlil_out_if result_ch ();

    text_line_index_and_lookup #(
        .MAX_LINES (TABLE_DEPTH),
        .MAX_BYTES (BUFFER_BYTES)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request_ch),
        .result  (result_ch)
    );

    logic [QUERY_W-1:0] start_table [TABLE_DEPTH];
    int unsigned        starts_used;
    int unsigned        text_len;
    bit                 cr_open;
    bit                 starts_dropped;

    line_pos_t   expected_positions [$];
    int unsigned mismatches;
    int unsigned send_idle_pct;
    int unsigned sink_stall_pct;
    int unsigned hold_len;
    logic        sink_hold;
    int unsigned cycle_count;

    function automatic void clear_line_index();
        starts_used    = 0;
        text_len       = 0;
        cr_open        = 1'b0;
        starts_dropped = 1'b0;
    endfunction

    function automatic bit note_line_start(int unsigned at);
        if (starts_used < TABLE_DEPTH)
        begin
            start_table[starts_used] = at[QUERY_W-1:0];
            starts_used++;
            return 1'b1;
        end
        starts_dropped = 1'b1;
        return 1'b0;
    endfunction

    function automatic void index_text_byte(logic [BYTE_W-1:0] data);
        if (text_len >= BUFFER_BYTES)
            return;
        text_len++;
        if (data == CHAR_LF)
        begin
            if (cr_open && starts_used > 0)
                start_table[starts_used-1] = text_len[QUERY_W-1:0];
            else
                void'(note_line_start(text_len));
            cr_open = 1'b0;
        end
        else if (data == CHAR_CR)
        begin
            cr_open = note_line_start(text_len);
        end
        else
        begin
            cr_open = 1'b0;
        end
    endfunction

    function automatic line_pos_t locate_offset(logic [QUERY_W-1:0] offset);
        line_pos_t   pos;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        int unsigned base;
        lo = 0;
        hi = starts_used;
        if (offset > text_len)
        begin
            pos.line   = '0;
            pos.column = '0;
            pos.status = STATUS_RANGE;
            return pos;
        end
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (start_table[mid] <= offset)
                lo = mid + 1;
            else
                hi = mid;
        end
        base       = (lo == 0) ? 0 : start_table[lo-1];
        pos.line   = LINE_W'(lo + 1);
        pos.column = COL_W'(offset - base + 1);
        pos.status = starts_dropped ? STATUS_OVERFLOW : STATUS_OK;
        return pos;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("text_line_index_and_lookup_tb: errors");
        $finish;
    end

    initial
    begin : long_hold
        sink_hold <= 1'b0;
        forever
        begin
            wait (hold_len != 0);
            @(posedge clk);
            sink_hold <= 1'b1;
            repeat (hold_len) @(posedge clk);
            sink_hold <= 1'b0;
            hold_len = 0;
        end
    end

    initial
    begin : result_check
        line_pos_t got;
        line_pos_t want;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
            begin
                got.line   = result_ch.line_number;
                got.column = result_ch.column_number;
                got.status = result_ch.status;
                if (expected_positions.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result: line %0d column %0d status %0d",
                                 got.line, got.column, got.status);
                end
                else
                begin
                    want = expected_positions.pop_front();
                    if (got.line !== want.line || got.column !== want.column ||
                        got.status !== want.status)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"result mismatch: expected line %0d column %0d ",
                                      "status %0d, got line %0d column %0d status %0d"},
                                     want.line, want.column, want.status,
                                     got.line, got.column, got.status);
                    end
                end
            end
            result_ch.ready <= rst_n && !sink_hold &&
                               ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    task automatic send_request(input logic [REQ_W-1:0] kind,
                                input logic [BYTE_W-1:0] data,
                                input logic [QUERY_W-1:0] offset);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            request_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        request_ch.valid        <= 1'b1;
        request_ch.req_type     <= kind;
        request_ch.text_byte    <= data;
        request_ch.query_offset <= offset;
        do
            @(posedge clk);
        while (!request_ch.ready);
        unique case (kind)
            REQ_APPEND: index_text_byte(data);
            REQ_QUERY:  expected_positions.insert(expected_positions.size(),
                                                  locate_offset(offset));
            REQ_CLEAR:  clear_line_index();
            default:    ;
        endcase
    endtask

    task automatic append_text(input logic [BYTE_W-1:0] data);
        send_request(REQ_APPEND, data, QUERY_W'($urandom));
    endtask

    task automatic query_at(input logic [QUERY_W-1:0] offset);
        send_request(REQ_QUERY, BYTE_W'($urandom), offset);
    endtask

    task automatic clear_text();
        send_request(REQ_CLEAR, BYTE_W'($urandom), QUERY_W'($urandom));
    endtask

    task automatic wait_for_results();
        request_ch.valid <= 1'b0;
        while (expected_positions.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_line_breaks();
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        clear_text();
        query_at(0);
        query_at(1);
        query_at({QUERY_W{1'b1}});
        append_text(8'h61);
        append_text(CHAR_LF);
        append_text(CHAR_CR);
        append_text(CHAR_LF);
        append_text(CHAR_CR);
        append_text(8'hFF);
        append_text(8'h00);
        append_text(CHAR_LF);
        for (int i = 0; i <= 9; i++)
            query_at(QUERY_W'(i));
        send_request(REQ_UNUSED, BYTE_W'($urandom), QUERY_W'($urandom));
        clear_text();
        query_at(0);
        query_at(1);
        wait_for_results();
    endtask

    task automatic test_random_text(input int unsigned items, input int unsigned src_pct,
                                    input int unsigned snk_pct);
        int unsigned sent;
        int unsigned roll;
        int unsigned pick;
        send_idle_pct  = src_pct;
        sink_stall_pct = snk_pct;
        sent = 0;
        while (sent < items)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 2)
            begin
                clear_text();
            end
            else if (roll < 4)
            begin
                send_request(REQ_UNUSED, BYTE_W'($urandom), QUERY_W'($urandom));
                sent--;
            end
            else if (roll < 28)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    query_at(QUERY_W'($urandom_range(0, text_len)));
                else if (pick < 8)
                    query_at(QUERY_W'(text_len));
                else if (pick < 9)
                    query_at(QUERY_W'(text_len + 1));
                else
                    query_at(QUERY_W'($urandom));
            end
            else if (roll < 38)
            begin
                append_text(CHAR_LF);
            end
            else if (roll < 45)
            begin
                append_text(CHAR_CR);
            end
            else if (roll < 50)
            begin
                append_text(CHAR_CR);
                append_text(CHAR_LF);
                sent++;
            end
            else if (roll < 60)
            begin
                append_text(BYTE_W'($urandom));
            end
            else
            begin
                append_text(BYTE_W'($urandom_range(8'h20, 8'h7E)));
            end
            sent++;
        end
        wait_for_results();
    endtask

    task automatic test_result_backlog();
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        clear_text();
        repeat (30)
        begin
            if ($urandom_range(0, 4) == 0)
                append_text(CHAR_LF);
            else
                append_text(BYTE_W'($urandom_range(8'h20, 8'h7E)));
        end
        hold_len = 400;
        repeat (40)
        begin
            query_at(QUERY_W'($urandom_range(0, text_len + 1)));
            if ($urandom_range(0, 3) == 0)
                append_text(CHAR_CR);
        end
        wait_for_results();
    endtask

    initial
    begin
        mismatches     = 0;
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        hold_len       = 0;
        clear_line_index();
        rst_n                   <= 1'b0;
        request_ch.valid        <= 1'b0;
        request_ch.req_type     <= REQ_APPEND;
        request_ch.text_byte    <= '0;
        request_ch.query_offset <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_line_breaks();
        test_random_text(400, 0, 0);
        test_random_text(400, 77, 0);
        test_random_text(400, 0, 77);
        test_random_text(400, 9, 9);
        test_result_backlog();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_positions.size() == 0)
            $display("text_line_index_and_lookup_tb: clean");
        else
            $display("text_line_index_and_lookup_tb: errors");
        $finish;
    end

endmodule
